// File: rtl/core/market_packet_tlv_parser_defines.svh
// Assertion helpers for the parser RTL.
`ifndef MARKET_PACKET_TLV_PARSER_DEFINES_SVH
`define MARKET_PACKET_TLV_PARSER_DEFINES_SVH

// Clocked assertion, disabled while in reset.
`define MPTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MPTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/mptp_pkg.sv
`default_nettype none
package mptp_pkg;

  localparam int unsigned MaxDatagramBytes = 4096;
  localparam int unsigned HdrLen           = 20;
  localparam int unsigned PosW             = $clog2(MaxDatagramBytes + 2);
  localparam int unsigned QueueDepth       = 2;

  localparam logic [31:0] TidReset = 32'h0000_F103;
  localparam logic [7:0]  ChainL   = 8'h4C;
  localparam logic [7:0]  ChainC   = 8'h43;
  localparam logic [15:0] IdLow    = 16'h2431;
  localparam logic [15:0] IdHigh   = 16'h2439;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StTooShort   = 3'd1;
  localparam logic [2:0] StBadChain   = 3'd2;
  localparam logic [2:0] StLenMismatch = 3'd3;
  localparam logic [2:0] StNotMarket  = 3'd4;

  localparam logic RegTid    = 1'b0;
  localparam logic RegEndian = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] field_id;
    logic [11:0] field_offset;
    logic        field_end;
    logic        datagram_done;
    logic [2:0]  status;
  } out_beat_t;

  // Queue entry: classified byte plus raw header bytes for the end check.
  typedef struct packed {
    logic            payload_valid;
    logic [7:0]      payload_byte;
    logic [15:0]     field_id;
    logic [11:0]     field_offset;
    logic            field_end;
    logic            datagram_done;
    logic [PosW-1:0] len;
    logic [7:0]      chain;
    logic [15:0]     clen_raw;
    logic [31:0]     tid_raw;
  } cmd_t;

  // a arrived first
  function automatic logic [15:0] word16(input logic be, input logic [7:0] a,
                                         input logic [7:0] b);
    return be ? {a, b} : {b, a};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/market_packet_tlv_parser.sv
// Streaming TLV parser for market data datagrams. One byte beat in per clock
// while in_stall_o is low, one result beat out per byte beat; the result beat
// goes from the front walker into the 2-entry queue and then into the output
// register before it is valid. Output stalls back up through the queue; with
// the queue full the input stalls. The first 20 bytes are captured as the
// header; records (id, size, payload) follow, and payload bytes of ids
// 0x2431..0x2439 come out with id and offset. The beat for the last byte
// carries datagram_done and the status. Byte order of header/record words is
// set by big_endian_wire.
// Config (APB): 0x0 expected transaction id, 0x4 big_endian_wire; write only
// while idle.
`default_nettype none
module market_packet_tlv_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire mptp_pkg::in_beat_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      mptp_pkg::out_beat_t out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);
  import mptp_pkg::*;

  logic [31:0] tid_q;
  logic        be_q;
  logic        accept, full, empty, pop, cfg_wr;
  cmd_t        cmd_in, cmd_out;

  // config regs
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      RegTid:    prdata = tid_q;
      RegEndian: prdata = {31'b0, be_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q <= TidReset;
      be_q  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegTid) tid_q <= pwdata;
      else be_q <= pwdata[0];
    end
  end

  // input side stalls only on a full queue
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mptp_front u_front (
    .clk_i, .rst_ni,
    .big_endian_i (be_q),
    .accept_i     (accept),
    .in_i         (in_data_i),
    .cmd_o        (cmd_in)
  );

  mptp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (accept),
    .push_data_i (cmd_in),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (cmd_out)
  );

  mptp_back u_back (
    .clk_i, .rst_ni,
    .tid_i        (tid_q),
    .big_endian_i (be_q),
    .empty_i      (empty),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule
`default_nettype wire

// File: rtl/core/mptp_front.sv
`default_nettype none
module mptp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             big_endian_i,
  input  wire logic             accept_i,
  input  wire mptp_pkg::in_beat_t in_i,
  output      mptp_pkg::cmd_t   cmd_o
);
  import mptp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      hdr_q [HdrLen];
  logic [15:0]     fl_q, fl_d;
  logic [2:0]      ph_q, ph_d;
  logic [23:0]     rh_q, rh_d;
  logic [15:0]     cf_q, cf_d;
  logic [15:0]     bl_q, bl_d;
  logic [11:0]     off_q, off_d;
  logic            is_hdr;
  logic [15:0]     bl_new;

  function automatic logic [7:0] hb(input logic [PosW-1:0] p, input logic [7:0] b,
                                    input logic [7:0] q, input int unsigned i);
    return (p == PosW'(i)) ? b : q;
  endfunction

  assign is_hdr = pos_q < PosW'(HdrLen);
  assign bl_new = word16(big_endian_i, rh_q[7:0], in_i.data_byte);

  always_comb begin
    pos_d = pos_q;
    fl_d  = fl_q;
    ph_d  = ph_q;
    rh_d  = rh_q;
    cf_d  = cf_q;
    bl_d  = bl_q;
    off_d = off_q;
    cmd_o = '0;
    if (is_hdr) begin
      if (pos_q == PosW'(HdrLen - 1)) begin
        fl_d = word16(big_endian_i, hdr_q[12], hdr_q[13]);
        ph_d = '0;
      end
    end else if (pos_q < PosW'(MaxDatagramBytes)) begin
      if (ph_q < 3'd4) begin
        if (fl_q != '0) begin
          rh_d = {rh_q[15:0], in_i.data_byte};
          ph_d = ph_q + 3'd1;
          if (ph_q == 3'd3) begin
            cf_d  = word16(big_endian_i, rh_q[23:16], rh_q[15:8]);
            bl_d  = bl_new;
            off_d = '0;
            if (bl_new == '0) begin
              fl_d = fl_q - 16'd1;
              ph_d = '0;
            end
          end
        end
      end else begin
        if (cf_q >= IdLow && cf_q <= IdHigh) begin
          cmd_o.payload_valid = 1'b1;
          cmd_o.payload_byte  = in_i.data_byte;
          cmd_o.field_id      = cf_q;
          cmd_o.field_offset  = off_q;
          cmd_o.field_end     = (bl_q == 16'd1);
        end
        off_d = off_q + 12'd1;
        bl_d  = bl_q - 16'd1;
        if (bl_q == 16'd1) begin
          fl_d = fl_q - 16'd1;
          ph_d = '0;
        end
      end
    end
    if (pos_q <= PosW'(MaxDatagramBytes)) pos_d = pos_q + PosW'(1);
    cmd_o.datagram_done = in_i.last_byte;
    cmd_o.len           = pos_d;
    cmd_o.chain         = hb(pos_q, in_i.data_byte, hdr_q[1], 1);
    cmd_o.clen_raw      = {hb(pos_q, in_i.data_byte, hdr_q[14], 14),
                           hb(pos_q, in_i.data_byte, hdr_q[15], 15)};
    cmd_o.tid_raw       = {hb(pos_q, in_i.data_byte, hdr_q[4], 4),
                           hb(pos_q, in_i.data_byte, hdr_q[5], 5),
                           hb(pos_q, in_i.data_byte, hdr_q[6], 6),
                           hb(pos_q, in_i.data_byte, hdr_q[7], 7)};
    if (in_i.last_byte) begin
      pos_d = '0; fl_d = '0; ph_d = '0; rh_d = '0;
      cf_d = '0; bl_d = '0; off_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; fl_q <= '0; ph_q <= '0; rh_q <= '0;
      cf_q <= '0; bl_q <= '0; off_q <= '0;
      for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d; fl_q <= fl_d; ph_q <= ph_d; rh_q <= rh_d;
      cf_q <= cf_d; bl_q <= bl_d; off_q <= off_d;
      if (is_hdr) hdr_q[pos_q[4:0]] <= in_i.data_byte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mptp_queue.sv
`default_nettype none
`include "market_packet_tlv_parser_defines.svh"
module mptp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mptp_pkg::cmd_t push_data_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           empty_o,
  output      mptp_pkg::cmd_t pop_data_o
);
  import mptp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o     = cnt_q == (PtrW+1)'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  `MPTP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= (PtrW+1)'(QueueDepth), "queue overfilled")
  `MPTP_ASSERT(a_no_push_full, full_o && !pop_i |-> !push_i, "push into full queue")
  `MPTP_ASSERT(a_no_pop_empty, empty_o |-> !pop_i, "pop from empty queue")
  `MPTP_ASSERT(a_cnt_step, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1,
               "count did not advance")

endmodule
`default_nettype wire

// File: rtl/core/mptp_back.sv
`default_nettype none
module mptp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [31:0]         tid_i,
  input  wire logic                big_endian_i,
  input  wire logic                empty_i,
  input  wire mptp_pkg::cmd_t      cmd_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      mptp_pkg::out_beat_t out_data_o
);
  import mptp_pkg::*;

  logic       vld_q;
  out_beat_t  out_q, out_d;
  logic [15:0] clen;
  logic [31:0] tid;
  logic [2:0]  st;

  assign clen = word16(big_endian_i, cmd_i.clen_raw[15:8], cmd_i.clen_raw[7:0]);
  assign tid  = big_endian_i ? cmd_i.tid_raw
              : {cmd_i.tid_raw[7:0], cmd_i.tid_raw[15:8],
                 cmd_i.tid_raw[23:16], cmd_i.tid_raw[31:24]};

  always_comb begin
    priority if (cmd_i.len < PosW'(HdrLen)) st = StTooShort;
    else if (cmd_i.chain != ChainL && cmd_i.chain != ChainC) st = StBadChain;
    else if (cmd_i.len > PosW'(MaxDatagramBytes) ||
             {3'b0, clen} != 19'(cmd_i.len) - 19'(HdrLen)) st = StLenMismatch;
    else if (tid != tid_i) st = StNotMarket;
    else st = StOk;
  end

  always_comb begin
    out_d.payload_valid = cmd_i.payload_valid;
    out_d.payload_byte  = cmd_i.payload_byte;
    out_d.field_id      = cmd_i.field_id;
    out_d.field_offset  = cmd_i.field_offset;
    out_d.field_end     = cmd_i.field_end;
    out_d.datagram_done = cmd_i.datagram_done;
    out_d.status        = cmd_i.datagram_done ? st : StOk;
  end

  assign pop_o       = !empty_i && (!vld_q || !out_stall_i);
  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire
